FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define LCDQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define LCDQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/lcdq_pkg.sv
// Types and constants of the paced character LCD write queue.
package lcdq_pkg;

	typedef enum logic [1:0] {
		OP_DATA = 2'd0,
		OP_CMD  = 2'd1,
		OP_TICK = 2'd2,
		OP_POLL = 2'd3
	} lcdq_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WR2,
		ST_RD1,
		ST_RD2
	} lcdq_state_t;

	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLEAR      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HOME       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_WAIT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_WAIT = 3'd5;

	localparam logic [7:0] RST_ESCAPE     = 8'd254;
	localparam logic [7:0] RST_INIT       = 8'd48;
	localparam logic [7:0] RST_CLEAR      = 8'd1;
	localparam logic [7:0] RST_HOME       = 8'd2;
	localparam logic [7:0] RST_LONG_WAIT  = 8'd6;
	localparam logic [7:0] RST_SHORT_WAIT = 8'd2;
	localparam logic [7:0] RESET_WAIT_MS  = 8'd6;
	localparam logic [7:0] MS_SATURATE    = 8'd255;

endpackage

FILE: hw/rtl/char_lcd_paced_write_queue_unit.sv
// Top level of the paced write queue for a character LCD.
//
//  Channel | Signals                                   | Direction | Transfer when
//  --------+-------------------------------------------+-----------+------------------------
//  in      | in_valid, in_stall, opcode, value          | into unit | in_valid && !in_stall
//  out     | out_valid, out_stall, write_*, overflow,   | out       | out_valid && !out_stall
//          | fill_count                                 |           |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data  | into unit | cfg_valid && cfg_ready
//
// A data push, a dropped push, a tick, or a poll that finds an empty queue or a wait not
// yet over, stays in ST_IDLE; a command push that fits passes through ST_WR2 (escape byte
// and code are two writes on the one write port of the ring store); a poll that sends a
// data byte or finds a lone escape byte passes through ST_RD1, and one that sends a command
// through ST_RD1 and ST_RD2 (one read of the store in each, whose read data is registered).
// Reset clears pointers, fill count and timer and sets wait and configuration to their reset
// values; the store itself is not cleared and only entries written since reset are ever read.
// A result stalled on the out side holds in_stall high until it is transferred.
module char_lcd_paced_write_queue_unit
	import lcdq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 128
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           opcode,
	input  logic [7:0]           value,

	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 write_valid,
	output logic                 write_is_command,
	output logic [7:0]           write_byte,
	output logic                 overflow,
	output logic [7:0]           fill_count,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	localparam int unsigned PW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	// Advance a ring pointer, wrapping at the queue depth (need not be a power of two).
	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	// Configuration registers
	logic [7:0] escape_q, init_q, clear_q, home_q, long_wait_q, short_wait_q;

	// Queue and pacing state
	lcdq_state_t   state_q, state_d;
	logic [PW-1:0] rd_ptr_q, rd_ptr_d;
	logic [PW-1:0] wr_ptr_q, wr_ptr_d;
	logic [CW-1:0] held_q, held_d;
	logic [7:0]    elapsed_q, elapsed_d;
	logic [7:0]    wait_q, wait_d;
	logic [7:0]    cmd_q;

	// Result register
	logic       out_valid_q;
	logic       res_valid_q, res_cmd_q, res_ovf_q;
	logic [7:0] res_byte_q, res_fill_q;

	// Store access
	logic          mem_we;
	logic [PW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_wdata, mem_rdata;

	// Per-cycle result
	logic       res_load;
	logic       r_valid, r_cmd, r_ovf;
	logic [7:0] r_byte;

	logic       in_fire, out_fire;
	logic       can_send, data_fits, cmd_fits, head_is_esc, pair_held, long_code;
	lcdq_op_t   op;

	assign op        = lcdq_op_t'(opcode);
	assign in_stall  = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign in_fire   = in_valid && !in_stall;
	assign out_fire  = out_valid_q && !out_stall;
	assign cfg_ready = 1'b1;

	assign data_fits   = held_q < CW'(QUEUE_DEPTH);
	assign cmd_fits    = held_q <= CW'(QUEUE_DEPTH - 2);
	assign can_send    = (held_q != '0) && (elapsed_q >= wait_q);
	assign head_is_esc = mem_rdata == escape_q;
	assign pair_held   = held_q >= CW'(2);
	assign long_code   = (mem_rdata == init_q) || (mem_rdata == clear_q) ||
		(mem_rdata == home_q);

	lcdq_ram #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH (8)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Next state: a command push takes a second write cycle, a sendable poll reads the
	// head and, when the head is the escape byte with its partner held, the code after it.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					case (op)
						OP_CMD:  state_d = cmd_fits ? ST_WR2 : ST_IDLE;
						OP_POLL: state_d = can_send ? ST_RD1 : ST_IDLE;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_RD1:  state_d = (head_is_esc && pair_held) ? ST_RD2 : ST_IDLE;
			ST_WR2:  state_d = ST_IDLE;
			ST_RD2:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath control and register updates for each state.
	always_comb begin
		rd_ptr_d  = rd_ptr_q;
		wr_ptr_d  = wr_ptr_q;
		held_d    = held_q;
		elapsed_d = elapsed_q;
		wait_d    = wait_q;
		mem_we    = 1'b0;
		mem_waddr = wr_ptr_q;
		mem_wdata = value;
		mem_raddr = rd_ptr_q;
		res_load  = 1'b0;
		r_valid   = 1'b0;
		r_cmd     = 1'b0;
		r_ovf     = 1'b0;
		r_byte    = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					case (op)
						OP_DATA: begin
							res_load = 1'b1;
							if (data_fits) begin
								mem_we   = 1'b1;
								wr_ptr_d = ptr_inc(wr_ptr_q);
								held_d   = held_q + CW'(1);
							end else begin
								r_ovf = 1'b1;
							end
						end
						OP_CMD: begin
							// Write the escape byte now, the code in the next cycle.
							if (cmd_fits) begin
								mem_we    = 1'b1;
								mem_wdata = escape_q;
								wr_ptr_d  = ptr_inc(wr_ptr_q);
								held_d    = held_q + CW'(2);
							end else begin
								res_load = 1'b1;
								r_ovf    = 1'b1;
							end
						end
						OP_TICK: begin
							res_load = 1'b1;
							if (elapsed_q != MS_SATURATE) begin
								elapsed_d = elapsed_q + 8'd1;
							end
						end
						OP_POLL: begin
							// Head read is issued at this edge; nothing to send ends here.
							res_load = !can_send;
						end
						default: res_load = 1'b1;
					endcase
				end
			end
			ST_WR2: begin
				mem_we    = 1'b1;
				mem_wdata = cmd_q;
				wr_ptr_d  = ptr_inc(wr_ptr_q);
				res_load  = 1'b1;
			end
			ST_RD1: begin
				mem_raddr = ptr_inc(rd_ptr_q);
				if (!head_is_esc) begin
					res_load = 1'b1;
					r_valid  = 1'b1;
					r_byte   = mem_rdata;
					rd_ptr_d = ptr_inc(rd_ptr_q);
					held_d   = held_q - CW'(1);
				end else begin
					// Hold a lone escape byte until its partner arrives.
					res_load = !pair_held;
				end
			end
			ST_RD2: begin
				res_load  = 1'b1;
				r_valid   = 1'b1;
				r_cmd     = 1'b1;
				r_byte    = mem_rdata;
				rd_ptr_d  = ptr_inc(ptr_inc(rd_ptr_q));
				held_d    = held_q - CW'(2);
				elapsed_d = '0;
				wait_d    = long_code ? long_wait_q : short_wait_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_ptr_q  <= '0;
			wr_ptr_q  <= '0;
			held_q    <= '0;
			elapsed_q <= '0;
			wait_q    <= RESET_WAIT_MS;
		end else begin
			state_q   <= state_d;
			rd_ptr_q  <= rd_ptr_d;
			wr_ptr_q  <= wr_ptr_d;
			held_q    <= held_d;
			elapsed_q <= elapsed_d;
			wait_q    <= wait_d;
		end
	end

	// Configuration writes; indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q     <= RST_ESCAPE;
			init_q       <= RST_INIT;
			clear_q      <= RST_CLEAR;
			home_q       <= RST_HOME;
			long_wait_q  <= RST_LONG_WAIT;
			short_wait_q <= RST_SHORT_WAIT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ESCAPE:     escape_q     <= cfg_data;
				CFG_INIT:       init_q       <= cfg_data;
				CFG_CLEAR:      clear_q      <= cfg_data;
				CFG_HOME:       home_q       <= cfg_data;
				CFG_LONG_WAIT:  long_wait_q  <= cfg_data;
				CFG_SHORT_WAIT: short_wait_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Latch the command code for the second write cycle.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q <= value;
		end
	end

	// Result valid: set on a new result, drop on transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_valid_q <= r_valid;
			res_cmd_q   <= r_cmd;
			res_byte_q  <= r_byte;
			res_ovf_q   <= r_ovf;
			res_fill_q  <= 8'(held_d);
		end
	end

	assign out_valid        = out_valid_q;
	assign write_valid      = res_valid_q;
	assign write_is_command = res_cmd_q;
	assign write_byte       = res_byte_q;
	assign overflow         = res_ovf_q;
	assign fill_count       = res_fill_q;

endmodule

FILE: hw/rtl/lcdq_ram.sv
// Single-port-write, single-port-read byte store with registered read data.
module lcdq_ram #(
	parameter int unsigned DEPTH = 128,
	parameter int unsigned WIDTH = 8
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/lcdq_checker.sv
// Port-level checker for the paced LCD write queue, bound to the top level.
`include "assert_macros.svh"

module lcdq_checker #(
	parameter int unsigned QUEUE_DEPTH = 128
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic                 write_valid,
	input logic                 write_is_command,
	input logic [7:0]           write_byte,
	input logic                 overflow,
	input logic [7:0]           fill_count
);

	`LCDQ_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(write_byte) && $stable(fill_count), "stalled result changed")
	`LCDQ_ASSERT(a_no_accept_on_stall, out_valid && out_stall |-> in_stall, "input taken while a result is stalled")
	`LCDQ_ASSERT(a_idle_fields, out_valid && !write_valid |-> !write_is_command && write_byte == 8'd0, "nonzero fields with nothing sent")
	`LCDQ_ASSERT(a_ovf_no_send, out_valid && overflow |-> !write_valid, "dropped push reported a send")
	`LCDQ_ASSERT(a_fill_bound, !out_valid || fill_count <= 8'(QUEUE_DEPTH), "fill count above queue depth")

endmodule

bind char_lcd_paced_write_queue_unit lcdq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_lcdq_checker (.*);
